// File: design/sfdm_pkg.sv
// Package for the stereo feedback delay mixer.
// Shared widths, register codes, FSM and handshake types, saturation helper.
// No dependencies.
`default_nettype none

package sfdm_pkg;

    // Sample and register widths
    localparam int SAMPLE_BITS    = 24;
    localparam int SUM_W          = SAMPLE_BITS + 4;
    localparam int DELAY_W        = 25;
    localparam int FB_W           = 16;
    localparam int MIX_W          = 17;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 25;
    localparam int LINE_DEPTH_DEF = 65536;

    // Limits and reset values of the registers
    localparam logic [FB_W-1:0]    FEEDBACK_MAX  = FB_W'(62259);
    localparam logic [MIX_W-1:0]   MIX_FULL      = MIX_W'(65536);
    localparam logic [DELAY_W-1:0] DELAY_RST     = DELAY_W'(1536000);
    localparam logic [FB_W-1:0]    FEEDBACK_RST  = FB_W'(19661);
    localparam logic [MIX_W-1:0]   MIX_RST       = MIX_W'(32768);

    // Register index codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BYPASS      = 3'd0,
        REG_LEFT_DELAY  = 3'd1,
        REG_RIGHT_DELAY = 3'd2,
        REG_FEEDBACK    = 3'd3,
        REG_WET_MIX     = 3'd4
    } t_cfg_reg;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_INTERP,
        S_MUL,
        S_COMMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // latch frame, start memory reads
        logic interp;   // register interpolated sample
        logic mul;      // register feedback and mix products
        logic commit;   // write memories, advance pointer, load output
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free; // output register empty or drained this cycle
    } t_sts;

    // Saturate a wide signed sum to the sample width
    function automatic logic [SAMPLE_BITS-1:0] sat(input logic [SUM_W-1:0] x);
        logic [SAMPLE_BITS-1:0] res;
        if (x[SUM_W-1:SAMPLE_BITS-1] == '0 || x[SUM_W-1:SAMPLE_BITS-1] == '1) begin
            res = x[SAMPLE_BITS-1:0];
        end else if (x[SUM_W-1]) begin
            res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: design/sfdm_chan.sv
// One channel of the delay mixer: delay memory, fractional read,
// interpolation, feedback and mix arithmetic. Uses sfdm_pkg.
`default_nettype none

module sfdm_chan #(
    parameter int LINE_DEPTH = sfdm_pkg::LINE_DEPTH_DEF
) (
    input  wire                                   i_clk,
    input  wire sfdm_pkg::t_cmd                   i_cmd,
    input  wire                                   i_bypass,
    input  wire [$clog2(LINE_DEPTH)-1:0]          i_wp,
    input  wire                                   i_wrapped,
    input  wire [sfdm_pkg::DELAY_W-1:0]           i_delay,
    input  wire [sfdm_pkg::FB_W-1:0]              i_fb,
    input  wire [sfdm_pkg::MIX_W-1:0]             i_mix,
    input  wire [sfdm_pkg::SAMPLE_BITS-1:0]       i_in,
    output logic [sfdm_pkg::SAMPLE_BITS-1:0]      o_out
);

    localparam int SB  = sfdm_pkg::SAMPLE_BITS;
    localparam int SW  = sfdm_pkg::SUM_W;
    localparam int AW  = $clog2(LINE_DEPTH);
    localparam int PW  = (AW + 9 > 26) ? AW + 9 : 26;
    localparam logic [PW-1:0] FULL = PW'(LINE_DEPTH * 256);

    // Delay memory and read-side registers
    logic [SB-1:0] r_mem [LINE_DEPTH];
    logic [SB-1:0] r_rd_a;
    logic [SB-1:0] r_rd_b;
    logic          r_va;
    logic          r_vb;
    logic [7:0]    r_f;
    logic signed [SB-1:0]    r_delayed;
    logic signed [SB+16:0]   r_fbp;
    logic signed [SB+18:0]   r_mixp;

    logic [PW-1:0] w_d;
    logic [PW-1:0] w_wp256;
    logic [PW-1:0] w_pos;
    logic [AW-1:0] w_i1;
    logic [AW-1:0] w_i2;

    logic [SB-1:0]          w_a;
    logic [SB-1:0]          w_b;
    logic signed [SB:0]     w_diff;
    logic signed [SB+9:0]   w_prod;
    logic signed [SB+9:0]   w_acc;
    logic signed [SB-1:0]   n_delayed;
    logic signed [SB:0]     w_wet_diff;
    logic signed [SB+16:0]  n_fbp;
    logic signed [SB+18:0]  n_mixp;
    logic [SB+16:0]         w_fb_rnd;
    logic [SB+18:0]         w_mix_rnd;
    logic [SW-1:0]          w_st_sum;
    logic [SW-1:0]          w_out_sum;
    logic [SB-1:0]          w_stored;

    // Read position behind the write pointer, delay clamped to the memory size
    always_comb begin
        w_d     = (PW'(i_delay) > FULL) ? FULL : PW'(i_delay);
        w_wp256 = PW'({i_wp, 8'h00});
        if (w_wp256 >= w_d) begin
            w_pos = w_wp256 - w_d;
        end else begin
            w_pos = w_wp256 + FULL - w_d;
        end
        w_i1 = w_pos[AW+7:8];
        w_i2 = (w_i1 == AW'(LINE_DEPTH - 1)) ? '0 : w_i1 + 1'b1;
    end

    // Two reads at frame load; entries not yet written read as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_a <= r_mem[w_i1];
            r_rd_b <= r_mem[w_i2];
            r_va   <= i_wrapped || (w_i1 < i_wp);
            r_vb   <= i_wrapped || (w_i2 < i_wp);
            r_f    <= w_pos[7:0];
        end
    end

    // Linear interpolation: a*256 + (b-a)*f, rounded
    always_comb begin
        w_a       = r_va ? r_rd_a : '0;
        w_b       = r_vb ? r_rd_b : '0;
        w_diff    = $signed({w_b[SB-1], w_b}) - $signed({w_a[SB-1], w_a});
        w_prod    = w_diff * $signed({1'b0, r_f});
        w_acc     = $signed({{2{w_a[SB-1]}}, w_a, 8'h00}) + w_prod
                    + $signed((SB+10)'(128));
        n_delayed = w_acc[SB+7:8];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.interp) begin
            r_delayed <= n_delayed;
        end
    end

    // Feedback and wet mix products
    always_comb begin
        w_wet_diff = $signed({r_delayed[SB-1], r_delayed}) - $signed({i_in[SB-1], i_in});
        n_fbp      = r_delayed * $signed({1'b0, i_fb});
        n_mixp     = w_wet_diff * $signed({1'b0, i_mix});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_fbp  <= n_fbp;
            r_mixp <= n_mixp;
        end
    end

    // Round, add to the input and saturate
    always_comb begin
        w_fb_rnd  = r_fbp + (SB+17)'(32768);
        w_mix_rnd = r_mixp + (SB+19)'(32768);
        w_st_sum  = {{(SW-SB){i_in[SB-1]}}, i_in}
                    + {{(SW-SB-1){w_fb_rnd[SB+16]}}, w_fb_rnd[SB+16:16]};
        w_out_sum = {{(SW-SB){i_in[SB-1]}}, i_in}
                    + {{(SW-SB-3){w_mix_rnd[SB+18]}}, w_mix_rnd[SB+18:16]};
        w_stored  = sfdm_pkg::sat(w_st_sum);
        o_out     = sfdm_pkg::sat(w_out_sum);
    end

    // Write-back after the reads of this frame
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !i_bypass) begin
            r_mem[i_wp] <= w_stored;
        end
    end

endmodule

`default_nettype wire

// File: design/sfdm_dpath.sv
// Datapath of the delay mixer: write pointer and fill tracking, frame and
// output registers, two channel units. Uses sfdm_pkg and sfdm_chan.
`default_nettype none

module sfdm_dpath #(
    parameter int LINE_DEPTH = sfdm_pkg::LINE_DEPTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire sfdm_pkg::t_cmd                i_cmd,
    output sfdm_pkg::t_sts                     o_sts,
    input  wire [2*sfdm_pkg::SAMPLE_BITS-1:0]  i_frame,
    input  wire                                i_bypass,
    input  wire [sfdm_pkg::DELAY_W-1:0]        i_left_delay,
    input  wire [sfdm_pkg::DELAY_W-1:0]        i_right_delay,
    input  wire [sfdm_pkg::FB_W-1:0]           i_fb,
    input  wire [sfdm_pkg::MIX_W-1:0]          i_mix,
    input  wire                                i_out_ready,
    output logic                               o_out_valid,
    output logic [2*sfdm_pkg::SAMPLE_BITS-1:0] o_out_frame
);

    localparam int SB = sfdm_pkg::SAMPLE_BITS;
    localparam int AW = $clog2(LINE_DEPTH);

    logic [AW-1:0] r_wp;
    logic          r_wrapped;
    logic [SB-1:0] r_in_left;
    logic [SB-1:0] r_in_right;
    logic          r_byp;
    logic          r_out_valid;
    logic [SB-1:0] r_out_left;
    logic [SB-1:0] r_out_right;
    logic [SB-1:0] w_left_out;
    logic [SB-1:0] w_right_out;

    // Frame latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_left  <= i_frame[SB-1:0];
            r_in_right <= i_frame[2*SB-1:SB];
            r_byp      <= i_bypass;
        end
    end

    // Shared write pointer; wrapped flag marks the whole memory as written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
        end else if (i_cmd.commit && !r_byp) begin
            if (r_wp == AW'(LINE_DEPTH - 1)) begin
                r_wp      <= '0;
                r_wrapped <= 1'b1;
            end else begin
                r_wp <= r_wp + 1'b1;
            end
        end
    end

    sfdm_chan #(.LINE_DEPTH(LINE_DEPTH)) u_left (
        .i_clk     (i_clk),
        .i_cmd     (i_cmd),
        .i_bypass  (r_byp),
        .i_wp      (r_wp),
        .i_wrapped (r_wrapped),
        .i_delay   (i_left_delay),
        .i_fb      (i_fb),
        .i_mix     (i_mix),
        .i_in      (r_in_left),
        .o_out     (w_left_out)
    );

    sfdm_chan #(.LINE_DEPTH(LINE_DEPTH)) u_right (
        .i_clk     (i_clk),
        .i_cmd     (i_cmd),
        .i_bypass  (r_byp),
        .i_wp      (r_wp),
        .i_wrapped (r_wrapped),
        .i_delay   (i_right_delay),
        .i_fb      (i_fb),
        .i_mix     (i_mix),
        .i_in      (r_in_right),
        .o_out     (w_right_out)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_left  <= r_byp ? r_in_left  : w_left_out;
            r_out_right <= r_byp ? r_in_right : w_right_out;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_frame    = {r_out_right, r_out_left};

endmodule

`default_nettype wire

// File: design/sfdm_ctrl.sv
// Frame sequencer of the delay mixer: steps one frame through load,
// interpolation, multiply and commit. Uses sfdm_pkg.
`default_nettype none

module sfdm_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire sfdm_pkg::t_sts  i_sts,
    output logic                 o_in_ready,
    output sfdm_pkg::t_cmd       o_cmd
);

    sfdm_pkg::t_state r_state;
    sfdm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfdm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sfdm_pkg::S_IDLE: begin
                if (i_in_valid) n_state = sfdm_pkg::S_INTERP;
            end
            sfdm_pkg::S_INTERP: n_state = sfdm_pkg::S_MUL;
            sfdm_pkg::S_MUL:    n_state = sfdm_pkg::S_COMMIT;
            sfdm_pkg::S_COMMIT: begin
                if (i_sts.out_free) n_state = sfdm_pkg::S_IDLE;
            end
            default: n_state = sfdm_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            sfdm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            sfdm_pkg::S_INTERP: o_cmd.interp = 1'b1;
            sfdm_pkg::S_MUL:    o_cmd.mul    = 1'b1;
            sfdm_pkg::S_COMMIT: o_cmd.commit = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: design/stereo_feedback_delay_mix_top.sv
// Stereo feedback delay mixer, top level: configuration registers,
// sequencer and datapath. Uses sfdm_pkg, sfdm_ctrl, sfdm_dpath.
//
// Usage:
//   One stereo frame per transfer on s_axis (left in the low 24 bits),
//   one blended frame per transfer on m_axis in the same layout.
//   Settings are written through i_cfg_we / i_cfg_addr / i_cfg_data while
//   the block is idle; unknown indexes are ignored.
// Sequence:
//   A frame accepted is processed in order: the memory read at
//   acceptance, the interpolation stage, the multiply stage and the commit
//   that writes both delay memories (not in bypass) and loads the output register. The next
//   frame is accepted only after the commit of the one before.
// Reset:
//   Registers return to their defaults and the write pointer to zero.
//   Memory entries not yet written since reset read as zero through the
//   write pointer and a wrap flag, so no clearing pass is needed and the
//   block is ready as soon as reset is released.
// Stall:
//   A finished frame waits in the output register; the next frame is
//   taken and processed meanwhile and holds at commit until m_axis drains.
`default_nettype none

module stereo_feedback_delay_mix_top #(
    parameter int LINE_DEPTH = sfdm_pkg::LINE_DEPTH_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Input stream
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire [2*sfdm_pkg::SAMPLE_BITS-1:0]   s_axis_tdata,   // left_in, right_in
    // Output stream
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [2*sfdm_pkg::SAMPLE_BITS-1:0]  m_axis_tdata,   // left_out, right_out
    // Configuration writes
    input  wire                                 i_cfg_we,
    input  wire [sfdm_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  wire [sfdm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic                             r_bypass;
    logic [sfdm_pkg::DELAY_W-1:0]     r_left_delay;
    logic [sfdm_pkg::DELAY_W-1:0]     r_right_delay;
    logic [sfdm_pkg::FB_W-1:0]        r_fb_gain;
    logic [sfdm_pkg::MIX_W-1:0]       r_wet_mix;
    logic [sfdm_pkg::FB_W-1:0]        w_fb;
    logic [sfdm_pkg::MIX_W-1:0]       w_mix;
    sfdm_pkg::t_cmd                   w_cmd;
    sfdm_pkg::t_sts                   w_sts;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass      <= 1'b0;
            r_left_delay  <= sfdm_pkg::DELAY_RST;
            r_right_delay <= sfdm_pkg::DELAY_RST;
            r_fb_gain     <= sfdm_pkg::FEEDBACK_RST;
            r_wet_mix     <= sfdm_pkg::MIX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                sfdm_pkg::REG_BYPASS:      r_bypass      <= i_cfg_data[0];
                sfdm_pkg::REG_LEFT_DELAY:  r_left_delay  <= i_cfg_data;
                sfdm_pkg::REG_RIGHT_DELAY: r_right_delay <= i_cfg_data;
                sfdm_pkg::REG_FEEDBACK:    r_fb_gain     <= i_cfg_data[sfdm_pkg::FB_W-1:0];
                sfdm_pkg::REG_WET_MIX:     r_wet_mix     <= i_cfg_data[sfdm_pkg::MIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Gain limits
    assign w_fb  = (r_fb_gain > sfdm_pkg::FEEDBACK_MAX) ? sfdm_pkg::FEEDBACK_MAX : r_fb_gain;
    assign w_mix = (r_wet_mix > sfdm_pkg::MIX_FULL) ? sfdm_pkg::MIX_FULL : r_wet_mix;

    sfdm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    sfdm_dpath #(.LINE_DEPTH(LINE_DEPTH)) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_frame       (s_axis_tdata),
        .i_bypass      (r_bypass),
        .i_left_delay  (r_left_delay),
        .i_right_delay (r_right_delay),
        .i_fb          (w_fb),
        .i_mix         (w_mix),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_frame   (m_axis_tdata)
    );

    // A new output appears only after a commit
    a_out_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.commit))
        else $error("output valid rose without a commit");

    // Commit never overwrites a result still waiting
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("commit over a pending result");

    // Input is taken only when no frame is in flight
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !(w_cmd.interp || w_cmd.mul || w_cmd.commit))
        else $error("ready while a frame is in flight");

    // A loaded frame moves to interpolation next cycle
    a_load_interp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> w_cmd.interp)
        else $error("load not followed by interpolation");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Testbench for the stereo feedback delay mixer top level.
// Checks each output frame against a cycle-free fixed-point model of both delay
// lines (fractional read, feedback, dry/wet blend). Depends on sfdm_pkg and the top.
`timescale 1ns / 1ps

module testbench;

    localparam int     SB            = sfdm_pkg::SAMPLE_BITS;
    localparam int     CDW           = sfdm_pkg::CFG_DATA_W;
    localparam int     CIW           = sfdm_pkg::CFG_IDX_W;
    localparam int     DEPTH         = sfdm_pkg::LINE_DEPTH_DEF;
    localparam int     RANDOM_FRAMES = 560;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     SETTLE_CYCLES = 8;
    localparam longint CYCLE_LIMIT   = 2_000_000;
    localparam longint SAT_HI        = 2**(SB-1) - 1;
    localparam longint SAT_LO        = -SAT_HI - 1;

    localparam logic [SB-1:0]  SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0]  SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic [CDW-1:0] DELAY_FULL = CDW'(DEPTH * 256);
    localparam logic [CDW-1:0] DELAY_TOP  = {CDW{1'b1}};

    // One stereo frame as it sits in tdata: left in the low bits
    typedef struct packed {
        logic signed [SB-1:0] right_s;
        logic signed [SB-1:0] left_s;
    } t_frame;

    // Delay line model plus store of expected output frames
    class delay_mix_scoreboard;
        int          line_mem [2*DEPTH];
        int          wr_ptr;
        bit          bypass_on;
        longint      delay_q8 [2];
        longint      fb_gain;
        longint      wet_gain;
        t_frame      expected_frames [$];
        int unsigned frames_checked;
        int unsigned frames_bypassed;
        int unsigned wraps;
        int unsigned errors;

        function new();
            foreach (line_mem[i]) line_mem[i] = 0;
            wr_ptr          = 0;
            bypass_on       = 1'b0;
            delay_q8[0]     = longint'(sfdm_pkg::DELAY_RST);
            delay_q8[1]     = longint'(sfdm_pkg::DELAY_RST);
            fb_gain         = longint'(sfdm_pkg::FEEDBACK_RST);
            wet_gain        = longint'(sfdm_pkg::MIX_RST);
            frames_checked  = 0;
            frames_bypassed = 0;
            wraps           = 0;
            errors          = 0;
        endfunction

        function void set_register(logic [CIW-1:0] idx, logic [CDW-1:0] val);
            case (idx)
                sfdm_pkg::REG_BYPASS:      bypass_on   = val[0];
                sfdm_pkg::REG_LEFT_DELAY:  delay_q8[0] = longint'(val[sfdm_pkg::DELAY_W-1:0]);
                sfdm_pkg::REG_RIGHT_DELAY: delay_q8[1] = longint'(val[sfdm_pkg::DELAY_W-1:0]);
                sfdm_pkg::REG_FEEDBACK:    fb_gain     = longint'(val[sfdm_pkg::FB_W-1:0]);
                sfdm_pkg::REG_WET_MIX:     wet_gain    = longint'(val[sfdm_pkg::MIX_W-1:0]);
                default: ;  // spare indexes are ignored
            endcase
        endfunction

        function longint clip(longint x);
            if (x > SAT_HI) return SAT_HI;
            if (x < SAT_LO) return SAT_LO;
            return x;
        endfunction

        // One channel: interpolated read, feedback write-back, blended output
        function logic signed [SB-1:0] mix_channel(int ch, longint x, longint fb, longint mix);
            longint full, dly, pos, f, acc, delayed, stored, blended;
            int     base, i1, i2;
            full = longint'(DEPTH) * 256;
            dly  = (delay_q8[ch] > full) ? full : delay_q8[ch];
            pos  = longint'(wr_ptr) * 256 - dly;
            if (pos < 0) pos += full;
            i1   = int'((pos >>> 8) % DEPTH);
            i2   = (i1 + 1) % DEPTH;
            f    = pos & 255;
            base = ch * DEPTH;
            acc  = longint'(line_mem[base + i1]) * (256 - f)
                 + longint'(line_mem[base + i2]) * f;
            delayed = (acc + 128) >>> 8;
            stored  = clip(x + ((delayed * fb + 32768) >>> 16));
            line_mem[base + wr_ptr] = int'(stored);
            blended = clip(x + (((delayed - x) * mix + 32768) >>> 16));
            return blended[SB-1:0];
        endfunction

        // Input transfer: compute the frame the block must return
        function void note_frame(logic [2*SB-1:0] data);
            t_frame in_f, out_f;
            longint fb, mix;
            in_f = t_frame'(data);
            if (bypass_on) begin
                out_f = in_f;
                frames_bypassed++;
            end else begin
                fb  = (fb_gain > longint'(sfdm_pkg::FEEDBACK_MAX)) ?
                      longint'(sfdm_pkg::FEEDBACK_MAX) : fb_gain;
                mix = (wet_gain > longint'(sfdm_pkg::MIX_FULL)) ?
                      longint'(sfdm_pkg::MIX_FULL) : wet_gain;
                out_f.left_s  = mix_channel(0, longint'(in_f.left_s), fb, mix);
                out_f.right_s = mix_channel(1, longint'(in_f.right_s), fb, mix);
                wr_ptr = (wr_ptr + 1) % DEPTH;
                if (wr_ptr == 0) wraps++;
            end
            expected_frames.insert(expected_frames.size(), out_f);
        endfunction

        function void flag_mismatch(string field, logic signed [SB-1:0] want,
                                    logic signed [SB-1:0] got);
            if (errors < 10)
                $display("Frame %0d %s: expected %0d, got %0d",
                         frames_checked, field, want, got);
            errors++;
        endfunction

        // Output transfer: compare with the oldest pending frame
        function void check_frame(logic [2*SB-1:0] data);
            t_frame got, want;
            got = t_frame'(data);
            if (expected_frames.size() == 0) begin
                if (errors < 10)
                    $display("Output transfer with no frame pending: left %0d, right %0d",
                             got.left_s, got.right_s);
                errors++;
                return;
            end
            want = expected_frames.pop_front();
            frames_checked++;
            if (got.left_s !== want.left_s)   flag_mismatch("left_out", want.left_s, got.left_s);
            if (got.right_s !== want.right_s) flag_mismatch("right_out", want.right_s, got.right_s);
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n       = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [2*SB-1:0] s_axis_tdata  = '0;   // left_in, right_in
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [2*SB-1:0] m_axis_tdata;         // left_out, right_out
    logic            i_cfg_we      = 1'b0;
    logic [CIW-1:0]  i_cfg_addr    = '0;
    logic [CDW-1:0]  i_cfg_data    = '0;

    // Stimulus control, each driven by one process only
    logic       idling_on   = 1'b0;
    logic [7:0] hold_ticket = '0;
    logic [7:0] hold_seen   = '0;
    int         hold_left   = 0;
    int         stall_left  = 0;
    int         settings_used = 0;
    longint     cycles;

    delay_mix_scoreboard sb;

    stereo_feedback_delay_mix_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Transfer monitors on both streams
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) sb.note_frame(s_axis_tdata);
        if (m_axis_tvalid && m_axis_tready) sb.check_frame(m_axis_tdata);
    end

    // Output sink: random stall bursts, plus a long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_ticket) begin
            hold_seen     <= hold_ticket;
            hold_left     <= HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 15);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d frame(s) pending", cycles, sb.pending());
        $display("FAILURE");
        $finish;
    end

    task automatic write_reg(input logic [CIW-1:0] idx, input logic [CDW-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_register(idx, val);
    endtask

    // Full register set, then junk to the spare indexes
    task automatic configure(input logic bp, input logic [CDW-1:0] left_d,
                             input logic [CDW-1:0] right_d,
                             input logic [sfdm_pkg::FB_W-1:0] fb,
                             input logic [sfdm_pkg::MIX_W-1:0] mix);
        logic [31:0] noise;
        write_reg(sfdm_pkg::REG_BYPASS, {{(CDW-1){1'b0}}, bp});
        write_reg(sfdm_pkg::REG_LEFT_DELAY, left_d);
        write_reg(sfdm_pkg::REG_RIGHT_DELAY, right_d);
        write_reg(sfdm_pkg::REG_FEEDBACK, CDW'(fb));
        write_reg(sfdm_pkg::REG_WET_MIX, CDW'(mix));
        for (int k = int'(sfdm_pkg::REG_WET_MIX) + 1; k < 2**CIW; k++) begin
            noise = $urandom;
            write_reg(k[CIW-1:0], noise[CDW-1:0]);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_frame(input logic [SB-1:0] left_s, input logic [SB-1:0] right_s);
        int gap;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 16);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right_s, left_s};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Stop offering and wait until every pending frame has come out
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic logic [SB-1:0] rand_sample();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            default: return w[SB-1:0];
        endcase
    endfunction

    // Mostly short delays that land on written entries, sometimes the extremes
    function automatic logic [CDW-1:0] rand_delay();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0:       w = 32'(DELAY_FULL);
            1:       ;  //   any 25-bit value, about half of them clamped
            2:       w = w & 32'hFF;
            default: w = $urandom_range(0, 1023) * 256 + (w & 32'hFF);
        endcase
        return w[CDW-1:0];
    endfunction

    function automatic logic [sfdm_pkg::FB_W-1:0] rand_feedback();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 7))
            0:       return sfdm_pkg::FEEDBACK_MAX;
            1:       return {sfdm_pkg::FB_W{1'b1}};
            default: return w[sfdm_pkg::FB_W-1:0];
        endcase
    endfunction

    function automatic logic [sfdm_pkg::MIX_W-1:0] rand_mix();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return sfdm_pkg::MIX_FULL;
            2:       return {sfdm_pkg::MIX_W{1'b1}};
            3:       return w[sfdm_pkg::MIX_W-1:0];
            default: begin
                w = $urandom_range(0, 65536);
                return w[sfdm_pkg::MIX_W-1:0];
            end
        endcase
    endfunction

    initial begin
        int n;
        int random_sent;
        int phase;
        logic bp;

        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: long delay over a cleared memory, half wet
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame(SAMPLE_MIN, SAMPLE_MAX);
        send_frame('0, '1);
        send_frame(24'd1, 24'h400000);
        settle();

        // One-sample and half-sample delay, top feedback, fully wet
        configure(1'b0, 25'd256, 25'd128, sfdm_pkg::FEEDBACK_MAX, sfdm_pkg::MIX_FULL);
        repeat (3) send_frame(SAMPLE_MAX, SAMPLE_MAX);
        repeat (2) send_frame(SAMPLE_MIN, SAMPLE_MIN);
        settle();

        // Left delay, feedback and mix above their limits and clamped; right delay at the memory size
        configure(1'b0, DELAY_TOP, DELAY_FULL, {sfdm_pkg::FB_W{1'b1}},
                  {sfdm_pkg::MIX_W{1'b1}});
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame(24'h123456, 24'hABCDEF);
        send_frame(SAMPLE_MIN, SAMPLE_MAX);
        settle();

        // Zero left delay (oldest entry), right delay just under one sample, fully dry, no feedback
        configure(1'b0, '0, 25'd255, '0, '0);
        send_frame(SAMPLE_MAX, 24'h000001);
        send_frame(24'hFFFFFE, SAMPLE_MIN);
        settle();

        // Bypass leaves the lines and the pointer alone
        configure(1'b1, 25'd512, 25'd384, 16'd1000, 17'd40000);
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame(SAMPLE_MIN, SAMPLE_MAX);
        send_frame(rand_sample(), rand_sample());
        settle();
        configure(1'b0, 25'd512, 25'd384, 16'd30000, 17'd50000);
        send_frame(rand_sample(), rand_sample());
        send_frame(rand_sample(), rand_sample());
        settle();

        // Random settings and content, idling on both sides
        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_FRAMES) begin
            idling_on <= ($urandom_range(0, 3) != 0);
            bp = (phase != 2) && ($urandom_range(0, 5) == 0);
            configure(bp, rand_delay(), rand_delay(), rand_feedback(), rand_mix());
            n = $urandom_range(20, 80);
            // long sink hold while frames keep coming
            if (phase == 2) hold_ticket <= hold_ticket + 8'd1;
            repeat (n) send_frame(rand_sample(), rand_sample());
            settle();
            random_sent += n;
            phase++;
        end

        // Last part, back to back: delays near and beyond the memory size
        idling_on <= 1'b0;
        configure(1'b0, CDW'((DEPTH - 1) * 256 + 77), rand_delay(),
                  rand_feedback(), rand_mix());
        repeat (40) send_frame(rand_sample(), rand_sample());
        settle();
        configure(1'b0, '0, DELAY_TOP, rand_feedback(), rand_mix());
        repeat (40) send_frame(rand_sample(), rand_sample());
        settle();
        configure(1'b0, 25'd128, CDW'((DEPTH - 1) * 256 + 255), sfdm_pkg::FEEDBACK_MAX,
                  sfdm_pkg::MIX_FULL);
        repeat (40) send_frame(rand_sample(), rand_sample());
        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d output frames (%0d in bypass) over %0d register settings.",
                 sb.frames_checked, sb.frames_bypassed, settings_used);
        $display("Write pointer wrapped %0d time(s); %0d failure(s), %0d frame(s) missing.",
                 sb.wraps, sb.errors, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
